### rtl/core/isometric_voxel_shade_project_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the isometric voxel shader
// Each macro checks one implication on clk_i with rst_ni as the disable.
// ----------------------------------------------------------------------------
`ifndef ISOMETRIC_VOXEL_SHADE_PROJECT_MACROS_SVH
`define ISOMETRIC_VOXEL_SHADE_PROJECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ivs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivs_pkg
// Types, constants and helper functions shared by the voxel shader modules.
// ----------------------------------------------------------------------------
package ivs_pkg;

  // Volume geometry.
  localparam int COORD_W       = 5;
  localparam int COORD_SPAN    = 32;
  localparam int DEF_SIZE_X    = 32;
  localparam int DEF_SIZE_Y    = 32;
  localparam int DEF_SIZE_Z    = 32;

  // Screen and color constants.
  localparam logic [10:0] SCREEN_LIMIT = 11'd1024;
  localparam logic [23:0] TINT_Z       = 24'h886655;
  localparam logic [23:0] TINT_Y       = 24'h000820;
  localparam logic [23:0] TINT_X       = 24'h443333;
  localparam logic [7:0]  CHAN_MAX     = 8'hFF;

  // Register reset values.
  localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd384;
  localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd216;
  localparam logic [10:0] RST_X_OFFSET      = 11'd192;
  localparam logic [10:0] RST_Y_OFFSET      = 11'd108;
  localparam logic [23:0] RST_PALETTE_1     = 24'h666666;
  localparam logic [23:0] RST_PALETTE_2     = 24'h999999;
  localparam logic [23:0] RST_PALETTE_3     = 24'h777777;

  // Request types.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_X_OFFSET      = 3'd2,
    CFG_Y_OFFSET      = 3'd3,
    CFG_PALETTE_1     = 3'd4,
    CFG_PALETTE_2     = 3'd5,
    CFG_PALETTE_3     = 3'd6
  } cfg_reg_e;

  // Neighbor fetched in each read slot of a render.
  typedef enum logic [2:0] {
    NB_CENTER = 3'd0,
    NB_DIAG   = 3'd1,
    NB_PX     = 3'd2,
    NB_PY     = 3'd3,
    NB_PZ     = 3'd4
  } nb_sel_e;

  // Render sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_EVAL,
    ST_CLIP,
    ST_EMIT
  } ivs_state_e;

  // Input transaction.
  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] vz;
    logic [1:0]         voxel_value;
  } ivs_in_t;

  // Output transaction, one per emitted pixel.
  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [23:0] pixel_color;
    logic        last_pixel;
  } ivs_out_t;

  // Request to the voxel store; coordinates carry one extra bit for +1.
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [COORD_W:0] cx;
    logic [COORD_W:0] cy;
    logic [COORD_W:0] cz;
    logic [1:0]       wdata;
  } ivs_mem_req_t;

  // Add two RGB 8:8:8 colors, clamping each channel at full scale.
  function automatic logic [23:0] sat_add_rgb(input logic [23:0] a, input logic [23:0] b);
    logic [8:0]  sum;
    logic [23:0] res;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      sum = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]};
      res[c*8 +: 8] = sum[8] ? CHAN_MAX : sum[7:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/ivs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivs_store
// Voxel volume memory with a shared address unit and a clearing pass.
// ----------------------------------------------------------------------------
module ivs_store
  import ivs_pkg::*;
#(
  parameter int SIZE_X = DEF_SIZE_X,
  parameter int SIZE_Y = DEF_SIZE_Y,
  parameter int SIZE_Z = DEF_SIZE_Z
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ivs_mem_req_t mem_req_i,
  output logic [1:0]   rd_data_o,
  output logic         clearing_o
);

  // Only coordinates that the input fields can reach are stored.
  localparam int EX     = (SIZE_X < COORD_SPAN) ? SIZE_X : COORD_SPAN;
  localparam int EY     = (SIZE_Y < COORD_SPAN) ? SIZE_Y : COORD_SPAN;
  localparam int EZ     = (SIZE_Z < COORD_SPAN) ? SIZE_Z : COORD_SPAN;
  localparam int DEPTH  = EX * EY * EZ;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [1:0]        mem_q [DEPTH];
  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              in_vol;
  logic [ADDR_W-1:0] addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [1:0]        mem_wdata;
  logic [1:0]        rd_data_q;
  logic              rd_in_q;

  // Bounds check and linear address of the requested cell.
  assign in_vol = (mem_req_i.cx < (COORD_W+1)'(EX)) &&
                  (mem_req_i.cy < (COORD_W+1)'(EY)) &&
                  (mem_req_i.cz < (COORD_W+1)'(EZ));
  assign addr   = ADDR_W'(mem_req_i.cx) +
                  ADDR_W'(mem_req_i.cy) * ADDR_W'(EX) +
                  ADDR_W'(mem_req_i.cz) * ADDR_W'(EX * EY);

  // The clearing pass owns the write port until it finishes.
  assign mem_we    = clr_q || (mem_req_i.wr && in_vol);
  assign mem_waddr = clr_q ? clr_addr_q : addr;
  assign mem_wdata = clr_q ? 2'd0 : mem_req_i.wdata;

  // Clearing pass, one cell per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd) begin
      rd_data_q <= mem_q[addr];
    end
  end

  // Remember whether the read cell was inside the volume.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_in_q <= 1'b0;
    end else if (mem_req_i.rd) begin
      rd_in_q <= in_vol;
    end
  end

  // Cells outside the volume read as empty.
  assign rd_data_o  = rd_in_q ? rd_data_q : 2'd0;
  assign clearing_o = clr_q;

endmodule

### rtl/core/isometric_voxel_shade_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isometric_voxel_shade_project
// Voxel volume with face shading and 2x2 isometric projection of voxels.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction  Content
//  in       in_valid_i/in_ready_o/in_data_i  sink       write or render request
//  out      out_valid_o/out_ready_i/out_data_o source   one shaded pixel
//  cfg      cfg_valid_i/cfg_ready_o/cfg_*_i  sink       register index and data
//
//  Writes can be accepted back to back. A render keeps the input not ready
//  while it makes 5 reads through the single read port, then drains,
//  evaluates, clips and emits the 4 pixels, stalling while the output is
//  held. A hidden voxel ends after evaluate, a fully clipped one after clip.
//  After reset a clearing pass zeroes the volume, one cell per cycle
//  (SIZE_X*SIZE_Y*SIZE_Z cells each capped at 32 per axis, 32768 by default);
//  input is not accepted meanwhile. Configuration writes are always accepted.
//  A finished pixel waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
`include "isometric_voxel_shade_project_macros.svh"

module isometric_voxel_shade_project
  import ivs_pkg::*;
#(
  parameter int SIZE_X = DEF_SIZE_X,
  parameter int SIZE_Y = DEF_SIZE_Y,
  parameter int SIZE_Z = DEF_SIZE_Z
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ivs_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ivs_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [23:0]          cfg_data_i
);

  ivs_state_e         state_q, state_d;
  nb_sel_e            sel_q, cap_sel_q;
  logic               cap_vld_q;
  logic [COORD_W-1:0] x_q, y_q, z_q;
  logic [1:0]         val_q;
  logic               diag_q, fx_q, fy_q, fz_q;
  logic [11:0]        bx_q, by_q, bx_d, by_d;
  logic [3:0]         mask_q, mask_d;
  logic [1:0]         pix_q;
  logic               out_valid_q;
  ivs_out_t           out_q;

  logic [10:0] width_q, height_q, x_off_q, y_off_q;
  logic [23:0] pal1_q, pal2_q, pal3_q;
  logic [10:0] w_lim, h_lim;

  ivs_mem_req_t mem_req;
  logic [1:0]   rd_data;
  logic         clearing;
  logic         in_acc;
  logic         slot_free, pix_on, pix_load, pix_adv;
  logic [11:0]  tx, ty;
  logic [23:0]  base_color, tint, pix_color;
  logic         pix_last;

  // Voxel store with its address unit.
  ivs_store #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .SIZE_Z (SIZE_Z)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mem_req_i  (mem_req),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_SCREEN_WIDTH;
      height_q <= RST_SCREEN_HEIGHT;
      x_off_q  <= RST_X_OFFSET;
      y_off_q  <= RST_Y_OFFSET;
      pal1_q   <= RST_PALETTE_1;
      pal2_q   <= RST_PALETTE_2;
      pal3_q   <= RST_PALETTE_3;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[10:0];
        CFG_X_OFFSET:      x_off_q  <= cfg_data_i[10:0];
        CFG_Y_OFFSET:      y_off_q  <= cfg_data_i[10:0];
        CFG_PALETTE_1:     pal1_q   <= cfg_data_i;
        CFG_PALETTE_2:     pal2_q   <= cfg_data_i;
        CFG_PALETTE_3:     pal3_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Screen size clamped so every emitted coordinate fits 10 bits.
  assign w_lim = (width_q > SCREEN_LIMIT) ? SCREEN_LIMIT : width_q;
  assign h_lim = (height_q > SCREEN_LIMIT) ? SCREEN_LIMIT : height_q;

  // Base screen position of the voxel footprint.
  assign bx_d = {6'd0, x_q, 1'b0} - {6'd0, y_q, 1'b0} + {x_off_q[10], x_off_q};
  assign by_d = {7'd0, x_q} + {7'd0, y_q} - {6'd0, z_q, 1'b0} + {y_off_q[10], y_off_q};

  // On-screen mask of the four pixels, bit index px*2+py.
  always_comb begin
    logic [11:0] cx;
    logic [11:0] cy;
    mask_d = '0;
    for (int p = 0; p < 4; p++) begin
      cx = bx_q + 12'(p / 2);
      cy = by_q + 12'(p % 2);
      mask_d[p] = !cx[11] && (cx[10:0] < w_lim) && !cy[11] && (cy[10:0] < h_lim);
    end
  end

  // Pixel currently being emitted.
  assign tx        = bx_q + {11'd0, pix_q[1]};
  assign ty        = by_q + {11'd0, pix_q[0]};
  assign pix_last  = ((mask_q & (4'b1110 << pix_q)) == 4'b0000);
  assign pix_color = sat_add_rgb(base_color, tint);

  // Palette lookup.
  always_comb begin
    unique case (val_q)
      2'd1:    base_color = pal1_q;
      2'd2:    base_color = pal2_q;
      2'd3:    base_color = pal3_q;
      default: base_color = '0;
    endcase
  end

  // Face tint from the open faces; both side faces split by column.
  always_comb begin
    priority if (fz_q) begin
      tint = TINT_Z;
    end else if (fx_q && !fy_q) begin
      tint = TINT_X;
    end else if (fy_q && !fx_q) begin
      tint = TINT_Y;
    end else if (fx_q && fy_q) begin
      tint = pix_q[1] ? TINT_X : TINT_Y;
    end else begin
      tint = '0;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.req_type == REQ_RENDER)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (sel_q == NB_PZ) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EVAL;
      ST_EVAL: begin
        state_d = ((val_q == 2'd0) || diag_q) ? ST_IDLE : ST_CLIP;
      end
      ST_CLIP: begin
        state_d = (mask_d == 4'b0000) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (pix_adv && (pix_q == 2'd3)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, memory requests and pixel emission.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && !clearing;
    in_acc     = in_valid_i && in_ready_o;
    slot_free  = !out_valid_q || out_ready_i;
    pix_on     = mask_q[pix_q];
    pix_load   = (state_q == ST_EMIT) && pix_on && slot_free;
    pix_adv    = (state_q == ST_EMIT) && (!pix_on || slot_free);
    mem_req    = '0;
    unique case (state_q)
      ST_IDLE: begin
        mem_req.wr    = in_acc && (in_data_i.req_type == REQ_WRITE);
        mem_req.cx    = {1'b0, in_data_i.vx};
        mem_req.cy    = {1'b0, in_data_i.vy};
        mem_req.cz    = {1'b0, in_data_i.vz};
        mem_req.wdata = in_data_i.voxel_value;
      end
      ST_FETCH: begin
        mem_req.rd = 1'b1;
        mem_req.cx = {1'b0, x_q};
        mem_req.cy = {1'b0, y_q};
        mem_req.cz = {1'b0, z_q};
        unique case (sel_q)
          NB_DIAG: begin
            mem_req.cx = {1'b0, x_q} + 1'b1;
            mem_req.cy = {1'b0, y_q} + 1'b1;
            mem_req.cz = {1'b0, z_q} + 1'b1;
          end
          NB_PX:   mem_req.cx = {1'b0, x_q} + 1'b1;
          NB_PY:   mem_req.cy = {1'b0, y_q} + 1'b1;
          NB_PZ:   mem_req.cz = {1'b0, z_q} + 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read slot counter and capture tag for returning read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= NB_CENTER;
      cap_sel_q <= NB_CENTER;
      cap_vld_q <= 1'b0;
    end else begin
      cap_vld_q <= (state_q == ST_FETCH);
      cap_sel_q <= sel_q;
      if (state_q == ST_FETCH) begin
        unique case (sel_q)
          NB_CENTER: sel_q <= NB_DIAG;
          NB_DIAG:   sel_q <= NB_PX;
          NB_PX:     sel_q <= NB_PY;
          NB_PY:     sel_q <= NB_PZ;
          default:   sel_q <= NB_CENTER;
        endcase
      end else begin
        sel_q <= NB_CENTER;
      end
    end
  end

  // Latch render coordinates on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_data_i.vx;
      y_q <= in_data_i.vy;
      z_q <= in_data_i.vz;
    end
  end

  // Capture the voxel value and the neighbor flags as reads return.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= 2'd0;
      diag_q <= 1'b0;
      fx_q   <= 1'b0;
      fy_q   <= 1'b0;
      fz_q   <= 1'b0;
    end else if (cap_vld_q) begin
      unique case (cap_sel_q)
        NB_CENTER: val_q  <= rd_data;
        NB_DIAG:   diag_q <= (rd_data != 2'd0);
        NB_PX:     fx_q   <= (rd_data == 2'd0);
        NB_PY:     fy_q   <= (rd_data == 2'd0);
        NB_PZ:     fz_q   <= (rd_data == 2'd0);
        default: ;
      endcase
    end
  end

  // Footprint position and on-screen mask.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      bx_q <= bx_d;
      by_q <= by_d;
    end
    if (state_q == ST_CLIP) begin
      mask_q <= mask_d;
    end
  end

  // Pixel counter walks the footprint in px-major order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= 2'd0;
    end else if (state_q == ST_CLIP) begin
      pix_q <= 2'd0;
    end else if (pix_adv) begin
      pix_q <= pix_q + 2'd1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (pix_load) begin
      out_q.pixel_x     <= tx[9:0];
      out_q.pixel_y     <= ty[9:0];
      out_q.pixel_color <= pix_color;
      out_q.last_pixel  <= pix_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Consistency checks of the sequencer.
  `IVS_ASSERT_NOW(a_clear_quiet, clearing, (!out_valid_q && (state_q == ST_IDLE)), "activity during clearing pass")
  `IVS_ASSERT_NOW(a_emit_visible, (state_q == ST_EMIT), ((val_q != 2'd0) && !diag_q), "emitting a hidden voxel")
  `IVS_ASSERT_NEXT(a_fetch_done, ((state_q == ST_FETCH) && (sel_q == NB_PZ)), (state_q == ST_DRAIN), "fetch did not end after last neighbor")
  `IVS_ASSERT_NEXT(a_render_start, (in_acc && (in_data_i.req_type == REQ_RENDER)), ((state_q == ST_FETCH) && (sel_q == NB_CENTER)), "render did not start fetch")

endmodule
